// ===== src/cst_pkg.sv =====
// Package for the scheduler tick engine: sizes, mode and register codes,
// the per-slot record type and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;

  localparam int MAX_PROCS = 16;
  localparam int SLOT_W    = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int BURST_W   = 10;
  localparam int PRIO_W    = 8;
  localparam int TIME_W    = 24;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 10;

  localparam logic [MODE_W-1:0] MODE_FCFS = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SJF  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SRTF = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PRIO = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RR   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [BURST_W-1:0] need;
    logic [BURST_W-1:0] served;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  arrival;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOADW,
    ST_SORT,
    ST_PICK,
    ST_RUN,
    ST_RUNW,
    ST_DONE
  } st_e;

endpackage
`default_nettype wire

// ===== src/cst_if.sv =====
// Valid/ready channel interfaces for tick words and result words.
// Depends on cst_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface cst_in_if import cst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              arrive;
  logic [SLOT_W-1:0] slot;
  logic [BURST_W-1:0] burst_length;
  logic [PRIO_W-1:0] prio_level;
  modport source (output valid, arrive, slot, burst_length, prio_level, input ready);
  modport sink (input valid, arrive, slot, burst_length, prio_level, output ready);
endinterface

interface cst_out_if import cst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              run_valid;
  logic [SLOT_W-1:0] run_slot;
  logic              finished;
  logic [TIME_W-1:0] finish_time;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] waiting;
  logic [CNT_W-1:0]  queued;
  modport source (output valid, run_valid, run_slot, finished, finish_time, turnaround,
                  waiting, queued, input ready);
  modport sink (input valid, run_valid, run_slot, finished, finish_time, turnaround,
                waiting, queued, output ready);
endinterface
`default_nettype wire

// ===== src/cst_rec_mem.sv =====
// Per-slot process record memory: one write port, one registered read port.
// Depends on cst_pkg for the record type.
`timescale 1ns / 1ps
`default_nettype none
module cst_rec_mem import cst_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [SLOT_W-1:0] waddr_i,
  input  wire rec_t              wdata_i,
  input  wire logic [SLOT_W-1:0] raddr_i,
  output rec_t                   rdata_o
);

  rec_t mem_q [MAX_PROCS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/cpu_scheduler_tick_engine.sv =====
// One input word is one scheduler tick; it yields exactly one result word. A tick
// passes through the pick, run and run-wait states when a process runs, and through
// the pick and done states when nothing runs. In SJF, SRTF and priority mode with
// more than one queued process, each queued entry's sort key is first fetched from
// the record memory, which has one registered read port, in a load and a load-wait
// state, then 16 odd-even transposition passes stably sort the queue. The next tick
// is taken once the current result has been loaded into the output register, so a
// stalled result channel holds the engine in its run-wait or done state.
`timescale 1ns / 1ps
`default_nettype none
module cpu_scheduler_tick_engine import cst_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  cst_in_if.sink                    in_s,
  cst_out_if.source                 out_s
);

  st_e state_q, state_d;
  logic [MODE_W-1:0]  mode_q;
  logic [BURST_W-1:0] quantum_q;
  logic [SLOT_W-1:0]  queue_q [MAX_PROCS];
  logic [SLOT_W-1:0]  queue_d [MAX_PROCS];
  logic [BURST_W-1:0] key_q [MAX_PROCS];
  logic [BURST_W-1:0] key_d [MAX_PROCS];
  logic [CNT_W-1:0]   count_q, count_d;
  logic               busy_q, busy_d;
  logic [SLOT_W-1:0]  cur_q, cur_d;
  logic [BURST_W-1:0] slice_q, slice_d;
  logic               requeue_q, requeue_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [CNT_W-1:0]   idx_q, idx_d;

  logic               ov_q, ov_d;
  logic               orv_q, orv_d;
  logic [SLOT_W-1:0]  ors_q, ors_d;
  logic               ofin_q, ofin_d;
  logic [TIME_W-1:0]  oft_q, oft_d;
  logic [TIME_W-1:0]  ota_q, ota_d;
  logic [TIME_W-1:0]  owt_q, owt_d;
  logic [CNT_W-1:0]   oq_q, oq_d;

  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr, mem_raddr;
  rec_t               mem_wdata, mem_rdata;

  logic [MODE_W-1:0]  mode_eff;
  logic               sort_mode;
  logic [BURST_W-1:0] q_eff;
  logic               out_free;
  logic               sort_go;
  logic               run_go;

  cst_rec_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign mode_eff  = (mode_q > MODE_RR) ? MODE_FCFS : mode_q;
  assign sort_mode = (mode_eff == MODE_SJF) || (mode_eff == MODE_SRTF) ||
                     (mode_eff == MODE_PRIO);
  assign q_eff     = (quantum_q == '0) ? BURST_W'(1) : quantum_q;
  assign out_free  = !ov_q || out_s.ready;
  assign in_s.ready = (state_q == ST_IDLE);

  assign out_s.valid       = ov_q;
  assign out_s.run_valid   = orv_q;
  assign out_s.run_slot    = ors_q;
  assign out_s.finished    = ofin_q;
  assign out_s.finish_time = oft_q;
  assign out_s.turnaround  = ota_q;
  assign out_s.waiting     = owt_q;
  assign out_s.queued      = oq_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_s.valid) state_d = sort_go ? ST_LOAD : ST_PICK;
      ST_LOAD:  state_d = ST_LOADW;
      ST_LOADW: state_d = (idx_q + CNT_W'(1) == count_q) ? ST_SORT : ST_LOAD;
      ST_SORT:  if (idx_q == CNT_W'(MAX_PROCS - 1)) state_d = ST_PICK;
      ST_PICK:  state_d = run_go ? ST_RUN : ST_DONE;
      ST_RUN:   state_d = ST_RUNW;
      ST_RUNW:  if (out_free) state_d = ST_IDLE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    logic               in_use;
    logic [CNT_W-1:0]   c;
    logic               b;
    logic [BURST_W-1:0] srv;
    logic [TIME_W-1:0]  ft;
    logic [TIME_W-1:0]  ta;

    for (int i = 0; i < MAX_PROCS; i++) begin
      queue_d[i] = queue_q[i];
      key_d[i]   = key_q[i];
    end
    count_d   = count_q;
    busy_d    = busy_q;
    cur_d     = cur_q;
    slice_d   = slice_q;
    requeue_d = requeue_q;
    now_d     = now_q;
    idx_d     = idx_q;
    ov_d      = ov_q && !out_s.ready;
    orv_d     = orv_q;
    ors_d     = ors_q;
    ofin_d    = ofin_q;
    oft_d     = oft_q;
    ota_d     = ota_q;
    owt_d     = owt_q;
    oq_d      = oq_q;
    mem_we    = 1'b0;
    mem_waddr = in_s.slot;
    mem_wdata = '0;
    mem_raddr = cur_q;
    sort_go   = 1'b0;
    run_go    = busy_q;
    in_use    = 1'b0;
    c         = count_q;
    b         = busy_q;
    srv       = '0;
    ft        = '0;
    ta        = '0;

    case (state_q)
      ST_IDLE: begin
        in_use = busy_q && (cur_q == in_s.slot);
        for (int i = 0; i < MAX_PROCS; i++) begin
          if ((CNT_W'(i) < count_q) && (queue_q[i] == in_s.slot)) in_use = 1'b1;
        end
        if (in_s.valid) begin
          if (in_s.arrive && !in_use &&
              (count_q + CNT_W'(busy_q) < CNT_W'(MAX_PROCS))) begin
            mem_we            = 1'b1;
            mem_wdata.need    = (in_s.burst_length == '0) ? BURST_W'(1) : in_s.burst_length;
            mem_wdata.served  = '0;
            mem_wdata.prio    = in_s.prio_level;
            mem_wdata.arrival = now_q;
            queue_d[c[SLOT_W-1:0]] = in_s.slot;
            c = c + CNT_W'(1);
          end
          // A slice that expired last tick, or an SRTF runner, goes back to the tail.
          if (requeue_q || ((mode_eff == MODE_SRTF) && b)) begin
            requeue_d = 1'b0;
            b = 1'b0;
            if (c < CNT_W'(MAX_PROCS)) begin
              queue_d[c[SLOT_W-1:0]] = cur_q;
              c = c + CNT_W'(1);
            end
          end
          count_d = c;
          busy_d  = b;
          idx_d   = '0;
          sort_go = sort_mode && (c > CNT_W'(1));
        end
      end
      ST_LOAD: begin
        mem_raddr = queue_q[idx_q[SLOT_W-1:0]];
      end
      ST_LOADW: begin
        case (mode_eff)
          MODE_SJF:  key_d[idx_q[SLOT_W-1:0]] = mem_rdata.need;
          MODE_SRTF: key_d[idx_q[SLOT_W-1:0]] = mem_rdata.need - mem_rdata.served;
          default:   key_d[idx_q[SLOT_W-1:0]] = BURST_W'(mem_rdata.prio);
        endcase
        idx_d = (idx_q + CNT_W'(1) == count_q) ? '0 : idx_q + CNT_W'(1);
      end
      ST_SORT: begin
        // Swap only on strictly greater keys so equal keys keep queue order.
        for (int j = 0; j < MAX_PROCS - 1; j++) begin
          if ((j % 2 == int'(idx_q[0])) && (CNT_W'(j + 1) < count_q) &&
              (key_q[j] > key_q[j+1])) begin
            queue_d[j]   = queue_q[j+1];
            queue_d[j+1] = queue_q[j];
            key_d[j]     = key_q[j+1];
            key_d[j+1]   = key_q[j];
          end
        end
        idx_d = idx_q + CNT_W'(1);
      end
      ST_PICK: begin
        if (!busy_q && (count_q != '0)) begin
          cur_d = queue_q[0];
          for (int i = 0; i < MAX_PROCS - 1; i++) begin
            queue_d[i] = queue_q[i+1];
            key_d[i]   = key_q[i+1];
          end
          count_d = count_q - CNT_W'(1);
          busy_d  = 1'b1;
          slice_d = '0;
          run_go  = 1'b1;
        end
      end
      ST_RUN: begin
        mem_raddr = cur_q;
      end
      ST_RUNW: begin
        if (out_free) begin
          srv       = mem_rdata.served + BURST_W'(1);
          mem_we    = 1'b1;
          mem_waddr = cur_q;
          mem_wdata = mem_rdata;
          mem_wdata.served = srv;
          ft = (now_q == TIME_MAX) ? TIME_MAX : now_q + TIME_W'(1);
          ta = (ft >= mem_rdata.arrival) ? ft - mem_rdata.arrival : '0;
          ov_d   = 1'b1;
          orv_d  = 1'b1;
          ors_d  = cur_q;
          ofin_d = 1'b0;
          oft_d  = '0;
          ota_d  = '0;
          owt_d  = '0;
          oq_d   = count_q;
          if (srv >= mem_rdata.need) begin
            ofin_d  = 1'b1;
            oft_d   = ft;
            ota_d   = ta;
            owt_d   = (ta >= TIME_W'(mem_rdata.need)) ? ta - TIME_W'(mem_rdata.need) : '0;
            busy_d  = 1'b0;
            slice_d = '0;
          end else if (mode_eff == MODE_SRTF) begin
            busy_d = 1'b0;
            if (count_q < CNT_W'(MAX_PROCS)) begin
              queue_d[count_q[SLOT_W-1:0]] = cur_q;
              count_d = count_q + CNT_W'(1);
              oq_d    = count_q + CNT_W'(1);
            end
          end else if (mode_eff == MODE_RR) begin
            slice_d = slice_q + BURST_W'(1);
            if (slice_q + BURST_W'(1) >= q_eff) begin
              requeue_d = 1'b1;
              slice_d   = '0;
            end
          end
          if (now_q != TIME_MAX) now_d = now_q + TIME_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ov_d   = 1'b1;
          orv_d  = 1'b0;
          ors_d  = '0;
          ofin_d = 1'b0;
          oft_d  = '0;
          ota_d  = '0;
          owt_d  = '0;
          oq_d   = count_q;
          if (now_q != TIME_MAX) now_d = now_q + TIME_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_FCFS;
      quantum_q <= BURST_W'(4);
      count_q   <= '0;
      busy_q    <= 1'b0;
      cur_q     <= '0;
      slice_q   <= '0;
      requeue_q <= 1'b0;
      now_q     <= '0;
      idx_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      busy_q    <= busy_d;
      cur_q     <= cur_d;
      slice_q   <= slice_d;
      requeue_q <= requeue_d;
      now_q     <= now_d;
      idx_q     <= idx_d;
      ov_q      <= ov_d;
      if (cfg_we_i && (cfg_idx_i == CFG_MODE)) mode_q <= cfg_data_i[MODE_W-1:0];
      if (cfg_we_i && (cfg_idx_i == CFG_QUANTUM)) quantum_q <= cfg_data_i[BURST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      queue_q[i] <= queue_d[i];
      key_q[i]   <= key_d[i];
    end
    orv_q  <= orv_d;
    ors_q  <= ors_d;
    ofin_q <= ofin_d;
    oft_q  <= oft_d;
    ota_q  <= ota_d;
    owt_q  <= owt_d;
    oq_q   <= oq_d;
  end

`ifndef SYNTH
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q + CNT_W'(busy_q)) <= CNT_W'(MAX_PROCS))
    else $error("queued plus running exceeds the slot table");

  a_requeue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    requeue_q |-> busy_q)
    else $error("requeue pending without a running process");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_s.ready) |=> (ov_q && $stable(oq_q)))
    else $error("result word lost while stalled");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for cpu_scheduler_tick_engine: drives tick words with bursty valid,
// stalls the result channel, and checks every result word against a behavioral scheduler.
// Depends on cst_pkg and the cst_in_if / cst_out_if channel interfaces.
`timescale 1ns / 1ps
module testbench;
  import cst_pkg::*;

  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;
  localparam int SETTLE_CYCLES = 80;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct packed {
    logic              run_valid;
    logic [SLOT_W-1:0] run_slot;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [CNT_W-1:0]  queued;
  } tick_res_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               arrive;
    logic [SLOT_W-1:0]  slot;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               known;
    tick_res_t          res;
  } dir_row_t;

  localparam int N_DIR = 22;
  dir_row_t dir_tab [N_DIR] = '{
    '{MODE_FCFS, 1'b1, 4'd0, 10'd1, 8'd0, 1'b1, '{1'b1, 4'd0, 1'b1, 24'd1, 24'd1, 24'd0, 5'd0}},
    '{MODE_FCFS, 1'b0, 4'd0, 10'd0, 8'd0, 1'b1, '{1'b0, 4'd0, 1'b0, 24'd0, 24'd0, 24'd0, 5'd0}},
    '{MODE_FCFS, 1'b1, 4'd15, 10'd0, 8'd255, 1'b1,
      '{1'b1, 4'd15, 1'b1, 24'd3, 24'd1, 24'd0, 5'd0}},
    '{MODE_FCFS, 1'b1, 4'd3, 10'd3, 8'd10, 1'b0, '0},
    '{MODE_FCFS, 1'b1, 4'd3, 10'd5, 8'd5, 1'b0, '0},
    '{MODE_FCFS, 1'b1, 4'd7, 10'd2, 8'd200, 1'b0, '0},
    '{MODE_FCFS, 1'b1, 4'd9, 10'd1, 8'd1, 1'b0, '0},
    '{MODE_SJF, 1'b1, 4'd2, 10'd4, 8'd0, 1'b0, '0},
    '{MODE_SJF, 1'b1, 4'd4, 10'd1, 8'd0, 1'b0, '0},
    '{MODE_SJF, 1'b1, 4'd6, 10'd2, 8'd0, 1'b0, '0},
    '{MODE_SJF, 1'b1, 4'd8, 10'd2, 8'd0, 1'b0, '0},
    '{MODE_SRTF, 1'b1, 4'd1, 10'd5, 8'd0, 1'b0, '0},
    '{MODE_SRTF, 1'b1, 4'd2, 10'd2, 8'd0, 1'b0, '0},
    '{MODE_SRTF, 1'b0, 4'd0, 10'd0, 8'd0, 1'b0, '0},
    '{MODE_PRIO, 1'b1, 4'd10, 10'd2, 8'd255, 1'b0, '0},
    '{MODE_PRIO, 1'b1, 4'd11, 10'd2, 8'd0, 1'b0, '0},
    '{MODE_PRIO, 1'b1, 4'd12, 10'd1, 8'd0, 1'b0, '0},
    '{MODE_RR, 1'b1, 4'd13, 10'd6, 8'd9, 1'b0, '0},
    '{MODE_RR, 1'b1, 4'd14, 10'd6, 8'd9, 1'b0, '0},
    '{MODE_RR, 1'b0, 4'd0, 10'd0, 8'd0, 1'b0, '0},
    '{MODE_RSVD5, 1'b1, 4'd5, 10'd2, 8'd3, 1'b0, '0},
    '{MODE_RSVD7, 1'b1, 4'd0, 10'd1, 8'd3, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  cst_in_if in_if ();
  cst_out_if out_if ();

  cpu_scheduler_tick_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_s(in_if), .out_s(out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Scheduler shadow state.
  logic [MODE_W-1:0] mode_sh = MODE_FCFS;
  int unsigned quantum_sh = 4;
  int unsigned ready_q [MAX_PROCS];
  int unsigned ready_n = 0;
  int unsigned need_sh [MAX_PROCS];
  int unsigned served_sh [MAX_PROCS];
  int unsigned prio_sh [MAX_PROCS];
  int unsigned arrival_sh [MAX_PROCS];
  bit running = 1'b0;
  int unsigned run_slot_sh = 0;
  int unsigned slice_sh = 0;
  bit requeue_sh = 1'b0;
  int unsigned now_sh = 0;

  tick_res_t results_due [$];
  tick_res_t known_due [$];
  bit known_flag [$];
  int unsigned accepted = 0, words_seen = 0, completions = 0, mismatches = 0;
  bit failed = 1'b0;

  function automatic void enqueue_slot(int unsigned s);
    if (ready_n < MAX_PROCS) begin
      ready_q[ready_n] = s;
      ready_n++;
    end
  endfunction

  function automatic int unsigned order_key(int unsigned s, logic [MODE_W-1:0] m);
    if (m == MODE_SJF) return need_sh[s];
    if (m == MODE_SRTF) return need_sh[s] - served_sh[s];
    return prio_sh[s];
  endfunction

  function automatic tick_res_t schedule_tick(logic a, logic [SLOT_W-1:0] s,
                                              logic [BURST_W-1:0] b, logic [PRIO_W-1:0] p);
    tick_res_t r;
    logic [MODE_W-1:0] m;
    int unsigned q, v, kv, j, ft, ta;
    bit in_use;
    r = '0;
    m = (mode_sh > MODE_RR) ? MODE_FCFS : mode_sh;
    q = (quantum_sh == 0) ? 1 : quantum_sh;
    in_use = running && run_slot_sh == s;
    for (int k = 0; k < ready_n; k++) if (ready_q[k] == s) in_use = 1'b1;
    if (a && !in_use && ready_n + (running ? 1 : 0) < MAX_PROCS) begin
      need_sh[s] = (b == 0) ? 1 : b;
      served_sh[s] = 0;
      prio_sh[s] = p;
      arrival_sh[s] = now_sh;
      enqueue_slot(s);
    end
    if (requeue_sh) begin
      requeue_sh = 1'b0;
      running = 1'b0;
      enqueue_slot(run_slot_sh);
    end
    if (m == MODE_SRTF && running) begin
      running = 1'b0;
      enqueue_slot(run_slot_sh);
    end
    if ((m == MODE_SJF || m == MODE_SRTF || m == MODE_PRIO) && ready_n > 1) begin
      // Insertion sort keeps equal keys in queue order.
      for (int i = 1; i < ready_n; i++) begin
        v = ready_q[i];
        kv = order_key(v, m);
        j = i;
        while (j > 0 && order_key(ready_q[j-1], m) > kv) begin
          ready_q[j] = ready_q[j-1];
          j--;
        end
        ready_q[j] = v;
      end
    end
    if (!running && ready_n > 0) begin
      run_slot_sh = ready_q[0];
      for (int k = 1; k < ready_n; k++) ready_q[k-1] = ready_q[k];
      ready_n--;
      running = 1'b1;
      slice_sh = 0;
    end
    if (running) begin
      r.run_valid = 1'b1;
      r.run_slot = SLOT_W'(run_slot_sh);
      served_sh[run_slot_sh] = (served_sh[run_slot_sh] + 1) & 1023;
      if (served_sh[run_slot_sh] >= need_sh[run_slot_sh]) begin
        ft = (now_sh < TIME_MAX) ? now_sh + 1 : TIME_MAX;
        ta = (ft >= arrival_sh[run_slot_sh]) ? ft - arrival_sh[run_slot_sh] : 0;
        r.finished = 1'b1;
        r.finish_time = TIME_W'(ft);
        r.turnaround = TIME_W'(ta);
        r.waiting = TIME_W'((ta >= need_sh[run_slot_sh]) ? ta - need_sh[run_slot_sh] : 0);
        running = 1'b0;
        slice_sh = 0;
      end else if (m == MODE_SRTF) begin
        enqueue_slot(run_slot_sh);
        running = 1'b0;
      end else if (m == MODE_RR) begin
        slice_sh = (slice_sh + 1) & 1023;
        if (slice_sh >= q) begin
          requeue_sh = 1'b1;
          slice_sh = 0;
        end
      end
    end
    if (now_sh < TIME_MAX) now_sh++;
    r.queued = CNT_W'(ready_n);
    return r;
  endfunction

  // Accepted tick words feed the shadow scheduler; result words are checked in order.
  always @(posedge clk_i) begin
    tick_res_t got, want, known_row;
    if (in_if.valid && in_if.ready) begin
      results_due.push_back(schedule_tick(in_if.arrive, in_if.slot, in_if.burst_length,
                                          in_if.prio_level));
      accepted++;
    end
    if (out_if.valid && out_if.ready) begin
      got = '{out_if.run_valid, out_if.run_slot, out_if.finished, out_if.finish_time,
              out_if.turnaround, out_if.waiting, out_if.queued};
      words_seen++;
      if (got.finished) completions++;
      if (results_due.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result word with nothing expected");
      end else begin
        want = results_due.pop_front();
        if (known_flag.size() > 0) begin
          // A typed-in row must agree with the shadow scheduler too.
          known_row = known_due.pop_front();
          if (known_flag.pop_front() && known_row !== want) begin
            failed = 1'b1;
            $display("ERROR: table row disagrees with scheduler prediction");
          end
        end
        if (got.run_valid !== want.run_valid || got.run_slot !== want.run_slot ||
            got.finished !== want.finished || got.finish_time !== want.finish_time ||
            got.turnaround !== want.turnaround || got.waiting !== want.waiting ||
            got.queued !== want.queued) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: word %0d exp run=%0d slot=%0d fin=%0d ft=%0d ta=%0d wt=%0d q=%0d",
                     words_seen, want.run_valid, want.run_slot, want.finished,
                     want.finish_time, want.turnaround, want.waiting, want.queued,
                     "  got run=%0d slot=%0d fin=%0d ft=%0d ta=%0d wt=%0d q=%0d",
                     got.run_valid, got.run_slot, got.finished, got.finish_time,
                     got.turnaround, got.waiting, got.queued);
        end
      end
    end
  end

  // Result channel back-pressure: one of four styles, redrawn at random.
  int unsigned stall_cyc = 0;
  int unsigned stall_style = 0;
  int unsigned stall_left = 0;
  initial out_if.ready = 1'b0;
  always @(negedge clk_i) begin
    stall_cyc++;
    if (stall_cyc % 100 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= (stall_cyc % 7) < 2;
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_if.ready <= 1'b0;
        end else begin
          stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
          out_if.ready <= 1'b1;
        end
      end
    endcase
  end

  task automatic send_tick(logic a, logic [SLOT_W-1:0] s, logic [BURST_W-1:0] b,
                           logic [PRIO_W-1:0] p);
    int unsigned start;
    start = accepted;
    in_if.valid = 1'b1;
    in_if.arrive = a;
    in_if.slot = s;
    in_if.burst_length = b;
    in_if.prio_level = p;
    do @(negedge clk_i); while (accepted == start);
  endtask

  // Called at a falling edge; returns at a falling edge with the block quiet.
  task automatic drain_results();
    in_if.valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    if (idx == CFG_MODE) mode_sh = data[MODE_W-1:0];
    else if (idx == CFG_QUANTUM) quantum_sh = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  int unsigned burst_left = 0;
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    logic [MODE_W-1:0] phase_modes [N_PHASES];
    logic [CFG_W-1:0] quanta [N_PHASES];
    logic [BURST_W-1:0] b;
    int unsigned pick;
    phase_modes = '{MODE_RR, MODE_SRTF, MODE_FCFS, MODE_SJF, MODE_PRIO, MODE_RR,
                    MODE_RSVD7, MODE_SRTF};
    quanta = '{10'd1, 10'd0, 10'd1023, 10'd3, 10'd2, 10'd1023, 10'd7, 10'd5};
    in_if.valid = 1'b0;
    in_if.arrive = 1'b0;
    in_if.slot = '0;
    in_if.burst_length = '0;
    in_if.prio_level = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].mode != mode_sh) begin
        drain_results();
        write_reg(CFG_MODE, CFG_W'(dir_tab[i].mode));
      end
      known_flag.push_back(dir_tab[i].known);
      known_due.push_back(dir_tab[i].res);
      send_tick(dir_tab[i].arrive, dir_tab[i].slot, dir_tab[i].burst, dir_tab[i].prio);
      pace_sender();
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      write_reg(CFG_MODE, CFG_W'(phase_modes[ph]));
      write_reg(CFG_QUANTUM, (ph == 3) ? CFG_W'($urandom_range(1, 1023)) : quanta[ph]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 199);
        if (pick == 0) b = 10'd1023;
        else if (pick < 6) b = BURST_W'($urandom_range(0, 1023));
        else if (pick < 20) b = BURST_W'($urandom_range(9, 40));
        else b = BURST_W'($urandom_range(0, 8));
        send_tick($urandom_range(0, 9) < 4, SLOT_W'($urandom_range(0, 15)), b,
                  PRIO_W'($urandom_range(0, 255)));
        // Let the result stream run dry once, midway through the third phase.
        if (ph == 2 && i == 100) drain_results();
        pace_sender();
      end
    end

    drain_results();
    $display("Ran %0d ticks through all modes and quantum extremes; %0d result words, %0d completions.",
             accepted, words_seen, completions);
    if (!failed && results_due.size() == 0) begin
      $display("cpu_scheduler_tick_engine verification clean");
    end else begin
      $display("%0d mismatching words", mismatches);
      $display("cpu_scheduler_tick_engine verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d result words outstanding.", results_due.size());
    $display("cpu_scheduler_tick_engine verification failed");
    $finish;
  end

endmodule
